// ----- src/bcp_pkg.sv -----
// Package for the cascaded balance controller: widths, limits, register
// indexes and the fixed-point helper functions. No dependencies.
`default_nettype none
package bcp_pkg;

  localparam int GAIN_W = 16;
  localparam int ERR_W  = 34;
  localparam int PROD_W = GAIN_W + ERR_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int OUT_W  = 32;
  localparam int INT_W  = 21;
  localparam int SC_W   = 6;
  localparam int AC_W   = 3;
  localparam int DUTY_W = ERR_W;
  localparam int MAG_W  = 12;
  localparam int STEER_W = 14;
  localparam int IDX_W  = 4;

  localparam int SPEED_DIVIDER_DEF = 50;
  localparam int ANGLE_DIVIDER_DEF = 5;

  localparam int SPEED_I_LIM   = 2000 * 256;
  localparam int RATE_I_LIM    = 3000 * 256;
  localparam int DUTY_LIM      = 3000;
  localparam int DEADBAND_PUSH = 100;

  localparam logic [IDX_W-1:0] REG_SPEED_TARGET   = 4'd0;
  localparam logic [IDX_W-1:0] REG_BALANCE_OFFSET = 4'd1;
  localparam logic [IDX_W-1:0] REG_SPEED_P_GAIN   = 4'd2;
  localparam logic [IDX_W-1:0] REG_SPEED_I_GAIN   = 4'd3;
  localparam logic [IDX_W-1:0] REG_ANGLE_P_GAIN   = 4'd4;
  localparam logic [IDX_W-1:0] REG_ANGLE_D_GAIN   = 4'd5;
  localparam logic [IDX_W-1:0] REG_RATE_P_GAIN    = 4'd6;
  localparam logic [IDX_W-1:0] REG_RATE_I_GAIN    = 4'd7;

  // Clamp a Q.8 sum to a symmetric limit.
  function automatic logic signed [ACC_W-1:0] clamp_acc(
    input logic signed [ACC_W-1:0] v, input int lim);
    logic signed [ACC_W-1:0] hi;
    hi = ACC_W'(lim);
    if (v > hi) return hi;
    if (v < -hi) return -hi;
    return v;
  endfunction

  // Divide a Q.8 sum by 256 toward zero, then saturate to 32 bits.
  function automatic logic signed [OUT_W-1:0] q8_out(input logic signed [ACC_W-1:0] q);
    logic signed [ACC_W-1:0] t;
    t = (q < 0) ? ((q + ACC_W'(255)) >>> 8) : (q >>> 8);
    if (t > ACC_W'(32'sh7fffffff)) return 32'sh7fffffff;
    if (t < -ACC_W'(33'sh080000000)) return 32'sh80000000;
    return t[OUT_W-1:0];
  endfunction

  // Saturate a motor duty to the PWM range.
  function automatic logic signed [DUTY_W-1:0] clamp_duty(input logic signed [DUTY_W-1:0] v);
    if (v > DUTY_W'(DUTY_LIM)) return DUTY_W'(DUTY_LIM);
    if (v < -DUTY_W'(DUTY_LIM)) return -DUTY_W'(DUTY_LIM);
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- src/balance_cascade_pid.sv -----
// Top level of the cascaded speed / angle / gyro-rate balance controller.
// Depends on bcp_pkg and bcp_ser_mul.
//
// Usage: one input beat per control tick carries tilt_angle, tilt_rate,
// wheel_speed and steer_duty; exactly one output beat per tick carries the
// left and right motor duty as magnitude plus forward bit.
// The user must write gains and targets (cfg_we / cfg_index / cfg_data) only
// while idle; the block does not enforce it. Indexes beyond seven are ignored.
//
// Sequencing: every loop product goes through one shared bit-serial
// multiplier that takes one gain bit per cycle; a product step issues the
// operands, shifts through all GAIN_W gain bits and hands the product off.
// A plain tick does the two rate-loop products, a tick on which the angle
// loop runs adds its two, and a tick on which the speed loop runs adds two
// more of its own. A new beat is accepted in the cycle after the result is
// loaded into the output register.
//
// Reset clears all configuration, integrators, held outputs and tick
// counters. When the receiver stalls, the finished result waits in the
// output register; the next tick is accepted and computed meanwhile, and it
// waits in its last step until the output register frees up.
`default_nettype none
module balance_cascade_pid #(
  parameter int SPEED_DIVIDER = bcp_pkg::SPEED_DIVIDER_DEF,
  parameter int ANGLE_DIVIDER = bcp_pkg::ANGLE_DIVIDER_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bcp_pkg::IDX_W-1:0]           cfg_index,
  input  logic [bcp_pkg::GAIN_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [15:0]                  tilt_angle,
  input  logic signed [15:0]                  tilt_rate,
  input  logic signed [15:0]                  wheel_speed,
  input  logic signed [bcp_pkg::STEER_W-1:0]  steer_duty,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bcp_pkg::MAG_W-1:0]           left_magnitude,
  output logic                                left_forward,
  output logic [bcp_pkg::MAG_W-1:0]           right_magnitude,
  output logic                                right_forward
);
  import bcp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SPD_I  = 8'b0000_0010,
    S_SPD_P  = 8'b0000_0100,
    S_ANG_P  = 8'b0000_1000,
    S_ANG_D  = 8'b0001_0000,
    S_RATE_I = 8'b0010_0000,
    S_RATE_P = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [GAIN_W-1:0] speed_target, balance_offset;
  logic signed [GAIN_W-1:0] speed_p_gain, speed_i_gain;
  logic signed [GAIN_W-1:0] angle_p_gain, angle_d_gain;
  logic signed [GAIN_W-1:0] rate_p_gain, rate_i_gain;

  // Latched tick inputs.
  logic signed [15:0]        angle_q, rate_q, speed_q;
  logic signed [STEER_W-1:0] steer_q;

  // Controller state.
  logic [SC_W-1:0]          sc_cnt;
  logic [AC_W-1:0]          ac_cnt;
  logic                     ang_run;
  logic signed [INT_W-1:0]  speed_integral, rate_integral;
  logic signed [ERR_W-1:0]  prev_err;
  logic signed [OUT_W-1:0]  held_speed, held_angle, g_out;
  logic signed [PROD_W-1:0] ang_acc;
  logic                     issued;

  logic [SC_W-1:0] sc_inc;
  logic [AC_W-1:0] ac_inc;
  logic            spd_hit, ang_hit;

  logic signed [ERR_W-1:0]  spd_err, ang_err, ang_diff, rate_err;
  logic signed [ERR_W-1:0]  mul_a;
  logic signed [GAIN_W-1:0] mul_b;
  logic                     is_mul, mul_start, mul_done;
  logic signed [PROD_W-1:0] mul_prod;
  logic signed [ACC_W-1:0]  spd_i_sum, rate_i_sum, spd_i_new, rate_i_new;
  logic signed [DUTY_W-1:0] g_push, left_d, right_d;

  assign in_ready = (state == S_IDLE);

  assign sc_inc  = sc_cnt + 1'b1;
  assign ac_inc  = ac_cnt + 1'b1;
  assign spd_hit = (sc_inc == SC_W'(SPEED_DIVIDER));
  assign ang_hit = (ac_inc == AC_W'(ANGLE_DIVIDER));

  // Loop errors; the angle error always fits in ERR_W bits and is not saturated.
  assign spd_err  = ERR_W'(speed_q) - ERR_W'(speed_target);
  assign ang_err  = ERR_W'(held_speed) + ERR_W'(balance_offset) - ERR_W'(angle_q);
  assign ang_diff = ang_err - prev_err;
  assign rate_err = ERR_W'(rate_q) - ERR_W'(held_angle);

  assign is_mul = (state == S_SPD_I) || (state == S_SPD_P) || (state == S_ANG_P) ||
                  (state == S_ANG_D) || (state == S_RATE_I) || (state == S_RATE_P);
  assign mul_start = is_mul && !issued;

  always_comb begin
    case (state)
      S_SPD_I:  begin mul_a = spd_err;  mul_b = speed_i_gain; end
      S_SPD_P:  begin mul_a = spd_err;  mul_b = speed_p_gain; end
      S_ANG_P:  begin mul_a = ang_err;  mul_b = angle_p_gain; end
      S_ANG_D:  begin mul_a = ang_diff; mul_b = angle_d_gain; end
      S_RATE_I: begin mul_a = rate_err; mul_b = rate_i_gain;  end
      S_RATE_P: begin mul_a = rate_err; mul_b = rate_p_gain;  end
      default:  begin mul_a = '0;       mul_b = '0;           end
    endcase
  end

  bcp_ser_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign spd_i_sum  = ACC_W'(speed_integral) + ACC_W'(mul_prod);
  assign rate_i_sum = ACC_W'(rate_integral) + ACC_W'(mul_prod);
  assign spd_i_new  = clamp_acc(spd_i_sum, SPEED_I_LIM);
  assign rate_i_new = clamp_acc(rate_i_sum, RATE_I_LIM);

  // Deadband push (zero counts as nonnegative) and the steering mix.
  assign g_push  = (g_out >= 0) ? (DUTY_W'(g_out) + DUTY_W'(DEADBAND_PUSH))
                                : (DUTY_W'(g_out) - DUTY_W'(DEADBAND_PUSH));
  assign left_d  = clamp_duty(g_push - DUTY_W'(steer_q));
  assign right_d = clamp_duty(g_push + DUTY_W'(steer_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      speed_target   <= '0;
      balance_offset <= '0;
      speed_p_gain   <= '0;
      speed_i_gain   <= '0;
      angle_p_gain   <= '0;
      angle_d_gain   <= '0;
      rate_p_gain    <= '0;
      rate_i_gain    <= '0;
      sc_cnt         <= '0;
      ac_cnt         <= '0;
      ang_run        <= 1'b0;
      speed_integral <= '0;
      rate_integral  <= '0;
      prev_err       <= '0;
      held_speed     <= '0;
      held_angle     <= '0;
      issued         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SPEED_TARGET:   speed_target   <= cfg_data;
          REG_BALANCE_OFFSET: balance_offset <= cfg_data;
          REG_SPEED_P_GAIN:   speed_p_gain   <= cfg_data;
          REG_SPEED_I_GAIN:   speed_i_gain   <= cfg_data;
          REG_ANGLE_P_GAIN:   angle_p_gain   <= cfg_data;
          REG_ANGLE_D_GAIN:   angle_d_gain   <= cfg_data;
          REG_RATE_P_GAIN:    rate_p_gain    <= cfg_data;
          REG_RATE_I_GAIN:    rate_i_gain    <= cfg_data;
          default: ;
        endcase
      end

      // The final step reloads the output register itself.
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end

      if (mul_start) begin
        issued <= 1'b1;
      end
      if (mul_done) begin
        issued <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            angle_q <= tilt_angle;
            rate_q  <= tilt_rate;
            speed_q <= wheel_speed;
            steer_q <= steer_duty;
            sc_cnt  <= spd_hit ? '0 : sc_inc;
            ac_cnt  <= ang_hit ? '0 : ac_inc;
            ang_run <= ang_hit;
            if (spd_hit) begin
              state <= S_SPD_I;
            end else if (ang_hit) begin
              state <= S_ANG_P;
            end else begin
              state <= S_RATE_I;
            end
          end
        end
        S_SPD_I: begin
          if (mul_done) begin
            speed_integral <= spd_i_new[INT_W-1:0];
            state <= S_SPD_P;
          end
        end
        S_SPD_P: begin
          if (mul_done) begin
            held_speed <= q8_out(ACC_W'(mul_prod) + ACC_W'(speed_integral));
            state <= ang_run ? S_ANG_P : S_RATE_I;
          end
        end
        S_ANG_P: begin
          if (mul_done) begin
            ang_acc <= mul_prod;
            state <= S_ANG_D;
          end
        end
        S_ANG_D: begin
          if (mul_done) begin
            held_angle <= q8_out(ACC_W'(ang_acc) + ACC_W'(mul_prod));
            prev_err <= ang_err;
            state <= S_RATE_I;
          end
        end
        S_RATE_I: begin
          if (mul_done) begin
            rate_integral <= rate_i_new[INT_W-1:0];
            state <= S_RATE_P;
          end
        end
        S_RATE_P: begin
          if (mul_done) begin
            g_out <= q8_out(ACC_W'(mul_prod) + ACC_W'(rate_integral));
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            left_magnitude  <= (left_d < 0) ? MAG_W'(-left_d) : MAG_W'(left_d);
            left_forward    <= (left_d >= 0);
            right_magnitude <= (right_d < 0) ? MAG_W'(-right_d) : MAG_W'(right_d);
            right_forward   <= (right_d >= 0);
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result never leaves the PWM range.
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_magnitude <= MAG_W'(DUTY_LIM)) && (right_magnitude <= MAG_W'(DUTY_LIM)))
    else $error("motor duty magnitude out of range");

  // The multiplier only finishes in a step that waits for it.
  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> is_mul && issued)
    else $error("multiplier finished outside a product step");

  // Tick counters clear instead of reaching their divider.
  a_cnt_wrap: assert property (@(posedge clk) disable iff (rst)
    (sc_cnt != SC_W'(SPEED_DIVIDER)) && (ac_cnt != AC_W'(ANGLE_DIVIDER)))
    else $error("tick counter reached its divider");

  // The speed integrator stays inside its clamp.
  a_int_clamp: assert property (@(posedge clk) disable iff (rst)
    (ACC_W'(speed_integral) <= ACC_W'(SPEED_I_LIM)) &&
    (ACC_W'(speed_integral) >= -ACC_W'(SPEED_I_LIM)))
    else $error("speed integrator outside its clamp");

endmodule
`default_nettype wire

// ----- src/bcp_ser_mul.sv -----
// Bit-serial signed multiplier: one gain bit per cycle, GAIN_W bits in all.
// Depends on bcp_pkg.
`default_nettype none
module bcp_ser_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [bcp_pkg::ERR_W-1:0]  a,
  input  logic signed [bcp_pkg::GAIN_W-1:0] b,
  output logic                              done,
  output logic signed [bcp_pkg::PROD_W-1:0] prod
);
  import bcp_pkg::*;

  localparam int CNT_W = $clog2(GAIN_W);

  logic                     busy;
  logic [CNT_W-1:0]         cnt;
  logic signed [PROD_W-1:0] mcand;
  logic [GAIN_W-1:0]        mplier;
  logic signed [PROD_W-1:0] addend;

  // The top gain bit carries negative weight.
  always_comb begin
    if (mplier[0]) begin
      addend = (cnt == CNT_W'(GAIN_W - 1)) ? -mcand : mcand;
    end else begin
      addend = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        mcand  <= PROD_W'(a);
        mplier <= b;
        prod   <= '0;
      end else if (busy) begin
        prod   <= prod + addend;
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == CNT_W'(GAIN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire
